### rtl/core/fdf_pkg.sv
// Shared types and constants of the flood duplicate filter.
// Request and result payloads, controller command and status, register bus widths.
`default_nettype none

package fdf_pkg;

	localparam int ID_W   = 8;
	localparam int TTL_W  = 4;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [TTL_W-1:0] INITIAL_TTL_RESET = 4'd5;

	localparam logic KIND_ORIGIN  = 1'b0;
	localparam logic KIND_NETWORK = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [ID_W-1:0]  msg_id;
		logic [ID_W-1:0]  peer_id;
		logic [TTL_W-1:0] ttl_in;
	} fdf_request_t;

	typedef struct packed {
		logic             deliver_valid;
		logic             forward_valid;
		logic [ID_W-1:0]  msg_out;
		logic [ID_W-1:0]  peer_out;
		logic [TTL_W-1:0] ttl_out;
	} fdf_result_t;

	typedef struct packed {
		logic capture;
		logic clear_wr;
		logic update;
	} fdf_cmd_t;

	typedef struct packed {
		logic clear_last;
	} fdf_status_t;

endpackage

`default_nettype wire

### rtl/core/flood_duplicate_filter_ttl_unit.sv
// Flood duplicate filter with TTL: a request is taken when start is high and busy is
// low; after the lookup state its result is registered and shown for one cycle with
// done high. A request is a registered read of the seen-bit row, then write-back of
// that row; busy is high during write-back, so a new request waits for it. After
// reset the block clears the seen store one row a cycle and holds busy high until the
// last row is cleared; the register port is served meanwhile. The receiver cannot
// stall: done is high for one cycle. Depends on fdf_pkg, fdf_ctrl, fdf_datapath, fdf_ram.
`default_nettype none

module flood_duplicate_filter_ttl_unit import fdf_pkg::*; #(
	parameter int MSG_IDS = 256,
	parameter int PEERS   = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire fdf_request_t      request,
	output fdf_result_t            result,
	output logic                   done,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [TTL_W-1:0] initial_ttl_q;
	fdf_cmd_t         cmd;
	fdf_status_t      status;

	assign pready = 1'b1;
	assign prdata = {{(APB_DW - TTL_W){1'b0}}, initial_ttl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			initial_ttl_q <= INITIAL_TTL_RESET;
		else if (psel && penable && pwrite && pready && (paddr == '0 || paddr != '0))
			initial_ttl_q <= pwdata[TTL_W-1:0];
	end

	fdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	fdf_datapath #(
		.MSG_IDS (MSG_IDS),
		.PEERS   (PEERS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.request     (request),
		.initial_ttl (initial_ttl_q),
		.result      (result),
		.done        (done)
	);

endmodule

`default_nettype wire

### rtl/core/fdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/fdf_ctrl.sv
// Controller of the flood duplicate filter: clear sweep, idle, row update.
// Depends on fdf_pkg for the command and status structs.
`default_nettype none

module fdf_ctrl import fdf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire fdf_status_t status,
	output fdf_cmd_t         cmd,
	output logic             busy
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

### rtl/core/fdf_datapath.sv
// Datapath of the flood duplicate filter: seen-bit row store, clear counter,
// identifier reduction tables and result register. Depends on fdf_pkg, fdf_ram.
`default_nettype none

module fdf_datapath import fdf_pkg::*; #(
	parameter int MSG_IDS = 256,
	parameter int PEERS   = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fdf_cmd_t         cmd,
	output fdf_status_t           status,
	input  wire fdf_request_t     request,
	input  wire logic [TTL_W-1:0] initial_ttl,
	output fdf_result_t           result,
	output logic                  done
);

	localparam int MSG_W  = (MSG_IDS > 1) ? $clog2(MSG_IDS) : 1;
	localparam int PEER_W = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int IDS    = 1 << ID_W;

	logic [MSG_W-1:0]  msg_mod  [IDS];
	logic [PEER_W-1:0] peer_mod [IDS];

	for (genvar i = 0; i < IDS; i++) begin : g_mod
		assign msg_mod[i]  = MSG_W'(i % MSG_IDS);
		assign peer_mod[i] = PEER_W'(i % PEERS);
	end

	fdf_request_t      req_q;
	logic [MSG_W-1:0]  msg_idx_q;
	logic [PEER_W-1:0] peer_idx_q;
	logic [MSG_W-1:0]  clr_q;
	fdf_result_t       result_q;
	logic              done_q;

	logic [PEERS-1:0]  row_rd;
	logic [PEERS-1:0]  row_set;
	logic [PEERS-1:0]  ram_wdata;
	logic [MSG_W-1:0]  ram_waddr;
	logic              ram_we;
	fdf_result_t       res_d;

	assign ram_we    = cmd.clear_wr | cmd.update;
	assign ram_waddr = cmd.clear_wr ? clr_q : msg_idx_q;
	assign ram_wdata = cmd.clear_wr ? '0 : row_set;

	fdf_ram #(
		.WIDTH (PEERS),
		.DEPTH (MSG_IDS)
	) u_seen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.capture),
		.raddr (msg_mod[request.msg_id]),
		.rdata (row_rd)
	);

	assign status.clear_last = (clr_q == MSG_W'(MSG_IDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear_wr)
			clr_q <= clr_q + MSG_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= request;
			msg_idx_q  <= msg_mod[request.msg_id];
			peer_idx_q <= peer_mod[request.peer_id];
		end
	end

	always_comb begin
		row_set             = row_rd;
		row_set[peer_idx_q] = 1'b1;
		res_d               = '0;
		if (req_q.kind == KIND_ORIGIN) begin
			res_d.deliver_valid = 1'b1;
			res_d.forward_valid = 1'b1;
			res_d.msg_out       = req_q.msg_id;
			res_d.peer_out      = req_q.peer_id;
			res_d.ttl_out       = initial_ttl;
		end else if (!row_rd[peer_idx_q]) begin
			res_d.deliver_valid = 1'b1;
			res_d.msg_out       = req_q.msg_id;
			res_d.peer_out      = req_q.peer_id;
			if (req_q.ttl_in != '0) begin
				res_d.forward_valid = 1'b1;
				res_d.ttl_out       = req_q.ttl_in - TTL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update)
			result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.update;
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench of the flood duplicate filter: directed and random requests under several
// initial_ttl settings and idle patterns, each result checked against a seen-bit tracker.
// Depends on fdf_pkg and flood_duplicate_filter_ttl_unit.
`default_nettype none

module tb_top;
	import fdf_pkg::*;

	localparam int MSG_IDS = 256;
	localparam int PEERS   = 256;
	localparam logic [APB_AW-1:0] ADDR_INITIAL_TTL = '0;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 300;

	class flood_tracker;
		bit               seen [MSG_IDS*PEERS];
		logic [TTL_W-1:0] origin_ttl;
		fdf_result_t      outcomes [$];
		int               errors;

		function new();
			origin_ttl = INITIAL_TTL_RESET;
			errors = 0;
		endfunction

		function void set_origin_ttl(logic [TTL_W-1:0] value);
			origin_ttl = value;
		endfunction

		function int pending();
			return outcomes.size();
		endfunction

		function void note_request(fdf_request_t req);
			int          idx;
			fdf_result_t r;
			idx = (int'(req.msg_id) % MSG_IDS) * PEERS + (int'(req.peer_id) % PEERS);
			r = '0;
			if (req.kind == KIND_ORIGIN) begin
				seen[idx] = 1'b1;
				r.deliver_valid = 1'b1;
				r.forward_valid = 1'b1;
				r.msg_out = req.msg_id;
				r.peer_out = req.peer_id;
				r.ttl_out = origin_ttl;
			end else if (!seen[idx]) begin
				seen[idx] = 1'b1;
				r.deliver_valid = 1'b1;
				r.msg_out = req.msg_id;
				r.peer_out = req.peer_id;
				if (req.ttl_in != '0) begin
					r.forward_valid = 1'b1;
					r.ttl_out = req.ttl_in - 1'b1;
				end
			end
			outcomes.push_back(r);
		endfunction

		function void check_result(fdf_result_t got);
			fdf_result_t want;
			if (outcomes.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = outcomes.pop_front();
			if (got.deliver_valid !== want.deliver_valid) begin
				$error("deliver_valid: expected %0d, got %0d", want.deliver_valid,
					got.deliver_valid);
				errors++;
			end
			if (got.forward_valid !== want.forward_valid) begin
				$error("forward_valid: expected %0d, got %0d", want.forward_valid,
					got.forward_valid);
				errors++;
			end
			if (got.msg_out !== want.msg_out) begin
				$error("msg_out: expected %0d, got %0d", want.msg_out, got.msg_out);
				errors++;
			end
			if (got.peer_out !== want.peer_out) begin
				$error("peer_out: expected %0d, got %0d", want.peer_out, got.peer_out);
				errors++;
			end
			if (got.ttl_out !== want.ttl_out) begin
				$error("ttl_out: expected %0d, got %0d", want.ttl_out, got.ttl_out);
				errors++;
			end
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	fdf_request_t      request = '0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic              busy;
	fdf_result_t       result;
	logic              done;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	logic [4:0] flood_msg_hi  = '0;
	logic [3:0] flood_peer_hi = '0;
	int         cycles = 0;

	flood_tracker track = new();

	flood_duplicate_filter_ttl_unit #(
		.MSG_IDS(MSG_IDS),
		.PEERS  (PEERS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.result (result),
		.done   (done),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[flood_duplicate_filter_ttl_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				track.note_request(request);
			if (done)
				track.check_result(result);
		end
	end

	function automatic fdf_request_t mk_request(logic kind, logic [ID_W-1:0] msg,
		logic [ID_W-1:0] peer, logic [TTL_W-1:0] ttl);
		fdf_request_t req;
		req.kind = kind;
		req.msg_id = msg;
		req.peer_id = peer;
		req.ttl_in = ttl;
		return req;
	endfunction

	// mostly copies of a few live floods, so duplicates are common
	function automatic fdf_request_t random_request();
		fdf_request_t req;
		req.kind = ($urandom_range(99) < 30) ? KIND_ORIGIN : KIND_NETWORK;
		if ($urandom_range(99) < 80)
			req.msg_id = {flood_msg_hi, 3'($urandom_range(7))};
		else
			req.msg_id = 8'($urandom());
		if ($urandom_range(99) < 80)
			req.peer_id = {flood_peer_hi, 4'($urandom_range(15))};
		else
			req.peer_id = 8'($urandom());
		if ($urandom_range(99) < 80)
			req.ttl_in = 4'($urandom_range(9));
		else
			req.ttl_in = 4'($urandom_range(15));
		return req;
	endfunction

	task automatic push_request(input fdf_request_t req, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (track.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_initial_ttl(input logic [TTL_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_INITIAL_TTL;
		pwdata <= ($urandom() & 32'hFFFF_FFF0) | APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		track.set_origin_ttl(value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DW'(value)) begin
			$error("prdata: expected %0d, got %0d", value, prdata);
			track.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input int idle_pct, input bit pause_midway);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 40 == 0) begin
				flood_msg_hi = 5'($urandom());
				flood_peer_hi = 4'($urandom());
			end
			if (pause_midway && i == PHASE_ITEMS / 2)
				drain();
			push_request(random_request(), idle_pct);
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(mk_request(KIND_NETWORK, 8'd0, 8'd0, 4'd0), 0);
		push_request(mk_request(KIND_NETWORK, 8'd0, 8'd0, 4'd5), 0);
		push_request(mk_request(KIND_ORIGIN, 8'd255, 8'd255, 4'd15), 0);
		push_request(mk_request(KIND_NETWORK, 8'd255, 8'd255, 4'd9), 0);
		push_request(mk_request(KIND_NETWORK, 8'd1, 8'd2, 4'd15), 0);
		push_request(mk_request(KIND_NETWORK, 8'd3, 8'd4, 4'd9), 0);
		push_request(mk_request(KIND_NETWORK, 8'd3, 8'd4, 4'd1), 0);
		push_request(mk_request(KIND_ORIGIN, 8'd3, 8'd4, 4'd0), 0);
		push_request(mk_request(KIND_NETWORK, 8'hAA, 8'h55, 4'd1), 0);
		push_request(mk_request(KIND_ORIGIN, 8'h55, 8'hAA, 4'd8), 0);
		push_request(mk_request(KIND_NETWORK, 8'h80, 8'h01, 4'd8), 0);
		push_request(mk_request(KIND_NETWORK, 8'h7F, 8'hFE, 4'd10), 0);
		drain();
		write_initial_ttl(4'd0);
		push_request(mk_request(KIND_ORIGIN, 8'd7, 8'd7, 4'd0), 0);
		push_request(mk_request(KIND_NETWORK, 8'd7, 8'd8, 4'd2), 0);
		drain();
		write_initial_ttl(4'd15);
		push_request(mk_request(KIND_ORIGIN, 8'd8, 8'd8, 4'd3), 0);
		push_request(mk_request(KIND_NETWORK, 8'd8, 8'd9, 4'd15), 0);
		drain();
		write_initial_ttl(4'd9);
		push_request(mk_request(KIND_ORIGIN, 8'd0, 8'd255, 4'd0), 0);
		push_request(mk_request(KIND_NETWORK, 8'd255, 8'd0, 4'd9), 0);
		drain();

		run_phase(0, 1'b0);
		write_initial_ttl(4'd0);
		run_phase(82, 1'b1);
		write_initial_ttl(4'd15);
		run_phase(0, 1'b0);
		write_initial_ttl(INITIAL_TTL_RESET);
		run_phase(21, 1'b0);

		if (track.errors == 0 && track.pending() == 0)
			$display("[flood_duplicate_filter_ttl_unit] OK");
		else
			$display("[flood_duplicate_filter_ttl_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
